### hdl/binary_table_column_format_parser_defines.svh
// assertion macros shared by the format parser checker
`ifndef BINARY_TABLE_COLUMN_FORMAT_PARSER_DEFINES_SVH
`define BINARY_TABLE_COLUMN_FORMAT_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define BTCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BTCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/btcf_pkg.sv
// shared constants and types for the column format parser
package btcf_pkg;

  // default width of the repeat count magnitude
  localparam int COUNT_BITS_DEF = 20;

  // width of the signed element count result
  localparam int ELEM_COUNT_W = 22;

  // special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // type letters
  localparam logic [7:0] LT_A = 8'h41;
  localparam logic [7:0] LT_B = 8'h42;
  localparam logic [7:0] LT_C = 8'h43;
  localparam logic [7:0] LT_D = 8'h44;
  localparam logic [7:0] LT_E = 8'h45;
  localparam logic [7:0] LT_I = 8'h49;
  localparam logic [7:0] LT_J = 8'h4A;
  localparam logic [7:0] LT_K = 8'h4B;
  localparam logic [7:0] LT_L = 8'h4C;
  localparam logic [7:0] LT_M = 8'h4D;
  localparam logic [7:0] LT_P = 8'h50;
  localparam logic [7:0] LT_Q = 8'h51;
  localparam logic [7:0] LT_X = 8'h58;

  // type class codes
  localparam logic [3:0] CLS_BYTE   = 4'd0;
  localparam logic [3:0] CLS_CHAR   = 4'd1;
  localparam logic [3:0] CLS_SHORT  = 4'd2;
  localparam logic [3:0] CLS_INT    = 4'd3;
  localparam logic [3:0] CLS_INT64  = 4'd4;
  localparam logic [3:0] CLS_FLOAT  = 4'd5;
  localparam logic [3:0] CLS_DOUBLE = 4'd6;
  localparam logic [3:0] CLS_VAR    = 4'd7;
  localparam logic [3:0] CLS_VAR64  = 4'd8;

  // what the scanner hands to the decoder at the end of a string
  typedef struct packed {
    logic [7:0] letter;
    logic       digits_seen;
    logic       is_negative;
  } btcf_fin_t;

endpackage

### hdl/btcf_scan.sv
// character scanner: whitespace, sign, repeat count digits and type letter
module btcf_scan #(
  parameter int COUNT_BITS = btcf_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [7:0]            ch,
  output btcf_pkg::btcf_fin_t   fin,
  output logic [COUNT_BITS-1:0] magnitude
);

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_SPACE = 5'b00010,
    PH_SIGN  = 5'b00100,
    PH_DIGIT = 5'b01000,
    PH_SKIP  = 5'b10000
  } phase_t;

  localparam int PW = COUNT_BITS + 4;
  localparam logic [PW-1:0] LIMIT = {{4{1'b0}}, {COUNT_BITS{1'b1}}};

  phase_t                phase, phase_next;
  logic [7:0]            first_char, first_char_next;
  logic                  digits_seen, digits_seen_next;
  logic                  is_negative, is_negative_next;
  logic [COUNT_BITS-1:0] magnitude_next;
  logic [7:0]            letter_held, letter_held_next;

  logic                  is_ws, is_digit, is_sign;
  logic [PW-1:0]         mag_ext, prod;
  logic [COUNT_BITS-1:0] mag_acc;

  // character classes
  assign is_ws    = (ch == btcf_pkg::CH_SPACE) ||
                    (ch inside {[btcf_pkg::CH_TAB:btcf_pkg::CH_CR]});
  assign is_digit = ch inside {[btcf_pkg::CH_ZERO:btcf_pkg::CH_NINE]};
  assign is_sign  = (ch == btcf_pkg::CH_PLUS) || (ch == btcf_pkg::CH_MINUS);

  // multiply by ten and add the digit, saturating
  assign mag_ext = {{4{1'b0}}, magnitude};
  assign prod    = (mag_ext << 3) + (mag_ext << 1) + {{(PW-4){1'b0}}, ch[3:0]};
  assign mag_acc = (prod > LIMIT) ? {COUNT_BITS{1'b1}} : prod[COUNT_BITS-1:0];

  // letter and count seen at the terminating character
  always_comb begin
    fin.digits_seen = digits_seen;
    fin.is_negative = is_negative;
    case (phase)
      PH_START: fin.letter = ch;
      PH_SPACE,
      PH_SIGN:  fin.letter = first_char;
      PH_DIGIT: fin.letter = btcf_pkg::CH_NUL;
      default:  fin.letter = letter_held;
    endcase
  end

  // next state for one character
  always_comb begin
    phase_next       = phase;
    first_char_next  = (phase == PH_START) ? ch : first_char;
    digits_seen_next = digits_seen;
    is_negative_next = is_negative;
    magnitude_next   = magnitude;
    letter_held_next = letter_held;
    if (ch == btcf_pkg::CH_NUL) begin
      phase_next       = PH_START;
      first_char_next  = '0;
      digits_seen_next = 1'b0;
      is_negative_next = 1'b0;
      magnitude_next   = '0;
      letter_held_next = '0;
    end else begin
      case (phase)
        PH_START, PH_SPACE: begin
          if (is_ws) begin
            phase_next = PH_SPACE;
          end else if (is_sign) begin
            is_negative_next = (ch == btcf_pkg::CH_MINUS);
            phase_next       = PH_SIGN;
          end else if (is_digit) begin
            magnitude_next   = mag_acc;
            digits_seen_next = 1'b1;
            phase_next       = PH_DIGIT;
          end else begin
            letter_held_next = first_char_next;
            phase_next       = PH_SKIP;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            magnitude_next   = mag_acc;
            digits_seen_next = 1'b1;
            phase_next       = PH_DIGIT;
          end else begin
            letter_held_next = first_char;
            phase_next       = PH_SKIP;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            magnitude_next = mag_acc;
          end else begin
            letter_held_next = ch;
            phase_next       = PH_SKIP;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      first_char  <= '0;
      digits_seen <= 1'b0;
      is_negative <= 1'b0;
      magnitude   <= '0;
      letter_held <= '0;
    end else if (adv) begin
      phase       <= phase_next;
      first_char  <= first_char_next;
      digits_seen <= digits_seen_next;
      is_negative <= is_negative_next;
      magnitude   <= magnitude_next;
      letter_held <= letter_held_next;
    end
  end

endmodule

### hdl/btcf_decode.sv
// type letter decode and element count
module btcf_decode #(
  parameter int COUNT_BITS = btcf_pkg::COUNT_BITS_DEF
) (
  input  btcf_pkg::btcf_fin_t                        fin,
  input  logic [COUNT_BITS-1:0]                      magnitude,
  output logic                                       ok,
  output logic [3:0]                                 type_class,
  output logic [4:0]                                 elem_bytes,
  output logic signed [btcf_pkg::ELEM_COUNT_W-1:0]   elem_count
);

  localparam int CW = (COUNT_BITS + 3 > btcf_pkg::ELEM_COUNT_W) ?
                      COUNT_BITS + 3 : btcf_pkg::ELEM_COUNT_W;

  logic [COUNT_BITS-1:0] mval;
  logic                  neg;
  logic [CW-1:0]         ext, dbl, eighth, one;
  logic [CW-1:0]         cnt_plain, cnt_dbl, cnt_bits;

  // repeat count, one when there were no digits
  assign mval   = fin.digits_seen ? magnitude : {{(COUNT_BITS-1){1'b0}}, 1'b1};
  assign neg    = fin.digits_seen && fin.is_negative;
  assign ext    = {{(CW-COUNT_BITS){1'b0}}, mval};
  assign dbl    = ext << 1;
  assign eighth = ext >> 3;
  assign one    = {{(CW-1){1'b0}}, 1'b1};

  assign cnt_plain = neg ? (~ext + one) : ext;
  assign cnt_dbl   = neg ? (~dbl + one) : dbl;

  // letter table
  always_comb begin
    ok         = 1'b1;
    type_class = btcf_pkg::CLS_BYTE;
    elem_bytes = 5'd1;
    cnt_bits   = cnt_plain;
    case (fin.letter)
      btcf_pkg::LT_X: cnt_bits = neg ? (one - eighth) : (one + eighth);
      btcf_pkg::LT_L,
      btcf_pkg::LT_B: cnt_bits = cnt_plain;
      btcf_pkg::LT_A: type_class = btcf_pkg::CLS_CHAR;
      btcf_pkg::LT_I: begin
        type_class = btcf_pkg::CLS_SHORT;
        elem_bytes = 5'd2;
      end
      btcf_pkg::LT_J: begin
        type_class = btcf_pkg::CLS_INT;
        elem_bytes = 5'd4;
      end
      btcf_pkg::LT_K: begin
        type_class = btcf_pkg::CLS_INT64;
        elem_bytes = 5'd8;
      end
      btcf_pkg::LT_E: begin
        type_class = btcf_pkg::CLS_FLOAT;
        elem_bytes = 5'd4;
      end
      btcf_pkg::LT_D: begin
        type_class = btcf_pkg::CLS_DOUBLE;
        elem_bytes = 5'd8;
      end
      btcf_pkg::LT_C: begin
        type_class = btcf_pkg::CLS_FLOAT;
        elem_bytes = 5'd8;
        cnt_bits   = cnt_dbl;
      end
      btcf_pkg::LT_M: begin
        type_class = btcf_pkg::CLS_DOUBLE;
        elem_bytes = 5'd16;
        cnt_bits   = cnt_dbl;
      end
      btcf_pkg::LT_P: begin
        type_class = btcf_pkg::CLS_VAR;
        elem_bytes = 5'd4;
        cnt_bits   = cnt_dbl;
      end
      btcf_pkg::LT_Q: begin
        type_class = btcf_pkg::CLS_VAR64;
        elem_bytes = 5'd8;
        cnt_bits   = cnt_dbl;
      end
      default: begin
        ok         = 1'b0;
        elem_bytes = 5'd0;
        cnt_bits   = '0;
      end
    endcase
  end

  // wrap to the result width
  assign elem_count = cnt_bits[btcf_pkg::ELEM_COUNT_W-1:0];

endmodule

### hdl/binary_table_column_format_parser.sv
// Column format parser top level. Takes one character per clock on ch and
// gives one result item per string when the terminating NUL has been
// processed. Sustained rate is one character per cycle: each character is
// held in the input register while the scanner applies its multiply-by-ten
// accumulate, and a result is loaded into the result register when its NUL
// leaves the input register. A NUL waits in the input register only while
// the previous result is still held by out_stall.
module binary_table_column_format_parser #(
  parameter int COUNT_BITS = btcf_pkg::COUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [7:0]                               ch,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     ok,
  output logic [3:0]                               type_class,
  output logic [4:0]                               elem_bytes,
  output logic signed [btcf_pkg::ELEM_COUNT_W-1:0] elem_count,
  output logic [7:0]                               type_letter
);

  logic                                     ch_valid;
  logic [7:0]                               ch_q;
  logic                                     adv, fin_load;
  btcf_pkg::btcf_fin_t                      fin;
  logic [COUNT_BITS-1:0]                    magnitude;
  logic                                     dec_ok;
  logic [3:0]                               dec_class;
  logic [4:0]                               dec_bytes;
  logic signed [btcf_pkg::ELEM_COUNT_W-1:0] dec_count;

  // a NUL needs a free result slot, other characters always advance
  assign adv      = ch_valid &&
                    ((ch_q != btcf_pkg::CH_NUL) || !out_valid || !out_stall);
  assign fin_load = adv && (ch_q == btcf_pkg::CH_NUL);
  assign in_stall = ch_valid && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (!in_stall) begin
      ch_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ch_q <= ch;
    end
  end

  btcf_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ch        (ch_q),
    .fin       (fin),
    .magnitude (magnitude)
  );

  btcf_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .fin        (fin),
    .magnitude  (magnitude),
    .ok         (dec_ok),
    .type_class (dec_class),
    .elem_bytes (dec_bytes),
    .elem_count (dec_count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      ok          <= dec_ok;
      type_class  <= dec_class;
      elem_bytes  <= dec_bytes;
      elem_count  <= dec_count;
      type_letter <= fin.letter;
    end
  end

endmodule

### hdl/btcf_checker.sv
// port-level checks for the column format parser, bound to the top level
`include "binary_table_column_format_parser_defines.svh"

module btcf_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_stall,
  input logic [7:0]                               ch,
  input logic                                     out_valid,
  input logic                                     out_stall,
  input logic                                     ok,
  input logic [3:0]                               type_class,
  input logic [4:0]                               elem_bytes,
  input logic signed [btcf_pkg::ELEM_COUNT_W-1:0] elem_count,
  input logic [7:0]                               type_letter
);

  // a stalled input item stays offered and unchanged
  `BTCF_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(ch), "input item changed")

  // a stalled result stays offered with an unchanged type letter
  `BTCF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(type_letter), "result dropped under stall")

  // a recognized letter always has a nonzero element width
  `BTCF_ASSERT_NOW(a_ok_bytes, out_valid && ok, elem_bytes != 5'd0, "valid type with no width")

  // an unrecognized letter clears the decoded fields
  `BTCF_ASSERT_NOW(a_bad_zero, out_valid && !ok, (elem_bytes == 5'd0) && (elem_count == '0) && (type_class == btcf_pkg::CLS_BYTE), "invalid result not cleared")

  // the P descriptor type is four bytes wide
  `BTCF_ASSERT_NOW(a_var_bytes, out_valid && ok && (type_class == btcf_pkg::CLS_VAR), elem_bytes == 5'd4, "descriptor width wrong")

endmodule

bind binary_table_column_format_parser btcf_checker u_btcf_checker (.*);

### dv/btcf_tb_pkg.sv
// format string predictor and result scoreboard for the column format parser bench
`timescale 1ns / 1ps
package btcf_tb_pkg;
  import btcf_pkg::*;

  // where the scanner stands within the current string
  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_SPACE,
    SCAN_SIGN,
    SCAN_DIGIT,
    SCAN_SKIP
  } scan_state_t;

  // one decoded column format
  typedef struct {
    logic                    ok;
    logic [3:0]              type_class;
    logic [4:0]              elem_bytes;
    logic [ELEM_COUNT_W-1:0] elem_count;
    logic [7:0]              type_letter;
  } fmt_result_t;

  localparam longint MAG_MAX = (longint'(1) << COUNT_BITS_DEF) - 1;

  class fmt_scoreboard;
    fmt_result_t               parsed_fmts[$];
    scan_state_t               state;
    logic [7:0]                first_ch;
    logic [7:0]                held_letter;
    logic                      digits_seen;
    logic                      is_negative;
    logic [COUNT_BITS_DEF-1:0] magnitude;
    int                        n_errors;
    int                        n_checked;
    int                        n_known;

    function new();
      clear_scan();
      n_errors  = 0;
      n_checked = 0;
      n_known   = 0;
    endfunction

    function void clear_scan();
      state       = SCAN_START;
      first_ch    = CH_NUL;
      held_letter = CH_NUL;
      digits_seen = 1'b0;
      is_negative = 1'b0;
      magnitude   = '0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // decimal accumulate, saturating at the magnitude width
    function void add_digit(logic [7:0] c);
      longint acc;
      acc = longint'(magnitude) * 10 + (longint'(c) - longint'(CH_ZERO));
      if (acc > MAG_MAX) acc = MAG_MAX;
      magnitude   = acc[COUNT_BITS_DEF-1:0];
      digits_seen = 1'b1;
      state       = SCAN_DIGIT;
    endfunction

    // decode the letter and repeat count held at the end of a string
    function fmt_result_t finish_fmt();
      fmt_result_t r;
      longint      n;
      longint      cnt;
      logic [7:0]  letter;
      if (state == SCAN_DIGIT) letter = CH_NUL;
      else if (state == SCAN_SKIP) letter = held_letter;
      else letter = first_ch;
      if (digits_seen) n = is_negative ? -longint'(magnitude) : longint'(magnitude);
      else n = 1;
      r.ok         = 1'b1;
      r.type_class = CLS_BYTE;
      r.elem_bytes = 5'd0;
      cnt          = 0;
      case (letter)
        LT_X: begin r.type_class = CLS_BYTE;   r.elem_bytes = 5'd1;  cnt = 1 + n / 8; end
        LT_L: begin r.type_class = CLS_BYTE;   r.elem_bytes = 5'd1;  cnt = n;         end
        LT_B: begin r.type_class = CLS_BYTE;   r.elem_bytes = 5'd1;  cnt = n;         end
        LT_A: begin r.type_class = CLS_CHAR;   r.elem_bytes = 5'd1;  cnt = n;         end
        LT_I: begin r.type_class = CLS_SHORT;  r.elem_bytes = 5'd2;  cnt = n;         end
        LT_J: begin r.type_class = CLS_INT;    r.elem_bytes = 5'd4;  cnt = n;         end
        LT_K: begin r.type_class = CLS_INT64;  r.elem_bytes = 5'd8;  cnt = n;         end
        LT_E: begin r.type_class = CLS_FLOAT;  r.elem_bytes = 5'd4;  cnt = n;         end
        LT_D: begin r.type_class = CLS_DOUBLE; r.elem_bytes = 5'd8;  cnt = n;         end
        LT_C: begin r.type_class = CLS_FLOAT;  r.elem_bytes = 5'd8;  cnt = 2 * n;     end
        LT_M: begin r.type_class = CLS_DOUBLE; r.elem_bytes = 5'd16; cnt = 2 * n;     end
        LT_P: begin r.type_class = CLS_VAR;    r.elem_bytes = 5'd4;  cnt = 2 * n;     end
        LT_Q: begin r.type_class = CLS_VAR64;  r.elem_bytes = 5'd8;  cnt = 2 * n;     end
        default: r.ok = 1'b0;
      endcase
      r.elem_count  = cnt[ELEM_COUNT_W-1:0];
      r.type_letter = letter;
      return r;
    endfunction

    // advance the scanner by one accepted character
    function void note_char(logic [7:0] c);
      if (state == SCAN_START) first_ch = c;
      if (c == CH_NUL) begin
        parsed_fmts.push_back(finish_fmt());
        clear_scan();
      end else begin
        case (state)
          SCAN_START, SCAN_SPACE: begin
            if (is_ws(c)) begin
              state = SCAN_SPACE;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              is_negative = (c == CH_MINUS);
              state       = SCAN_SIGN;
            end else if (is_digit(c)) begin
              add_digit(c);
            end else begin
              held_letter = first_ch;
              state       = SCAN_SKIP;
            end
          end
          SCAN_SIGN: begin
            if (is_digit(c)) begin
              add_digit(c);
            end else begin
              held_letter = first_ch;
              state       = SCAN_SKIP;
            end
          end
          SCAN_DIGIT: begin
            if (is_digit(c)) begin
              add_digit(c);
            end else begin
              held_letter = c;
              state       = SCAN_SKIP;
            end
          end
          default: ;
        endcase
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t MISMATCH: %s", $time, msg);
      n_errors++;
    endtask

    // compare one accepted result with the oldest expected format
    task check_result(logic ok_o, logic [3:0] cls_o, logic [4:0] bytes_o,
                      logic [ELEM_COUNT_W-1:0] cnt_o, logic [7:0] letter_o);
      fmt_result_t e;
      n_checked++;
      if (parsed_fmts.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, letter %02h", letter_o));
      end else begin
        e = parsed_fmts.pop_front();
        if (e.ok) n_known++;
        if (ok_o !== e.ok)
          report_mismatch($sformatf("ok %b, expected %b", ok_o, e.ok));
        if (cls_o !== e.type_class)
          report_mismatch($sformatf("type_class %0d, expected %0d", cls_o, e.type_class));
        if (bytes_o !== e.elem_bytes)
          report_mismatch($sformatf("elem_bytes %0d, expected %0d", bytes_o, e.elem_bytes));
        if (cnt_o !== e.elem_count)
          report_mismatch($sformatf("elem_count %h, expected %h", cnt_o, e.elem_count));
        if (letter_o !== e.type_letter)
          report_mismatch($sformatf("type_letter %02h, expected %02h", letter_o,
                                    e.type_letter));
      end
    endtask
  endclass

endpackage

### dv/tb.sv
// top level bench for the column format parser: directed and random format strings
`timescale 1ns / 1ps
module tb;
  import btcf_pkg::*;
  import btcf_tb_pkg::*;

  localparam int QUIET_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CHARS_PER_PHASE = 265;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [7:0]                     ch        = 8'h00;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           ok;
  logic [3:0]                     type_class;
  logic [4:0]                     elem_bytes;
  logic signed [ELEM_COUNT_W-1:0] elem_count;
  logic [7:0]                     type_letter;

  fmt_scoreboard sb;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int chars_sent     = 0;
  int strings_sent   = 0;
  int quiet_cycles   = 0;

  binary_table_column_format_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .type_class (type_class),
    .elem_bytes (elem_bytes),
    .elem_count (elem_count),
    .type_letter(type_letter)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // check every accepted result item
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(ok, type_class, elem_bytes, elem_count, type_letter);
  end

  // end the run when no item moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one character, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(c);
    chars_sent++;
    if (c == CH_NUL) strings_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(12))
      0:       return LT_X;
      1:       return LT_L;
      2:       return LT_B;
      3:       return LT_A;
      4:       return LT_I;
      5:       return LT_J;
      6:       return LT_K;
      7:       return LT_E;
      8:       return LT_D;
      9:       return LT_C;
      10:      return LT_M;
      11:      return LT_P;
      default: return LT_Q;
    endcase
  endfunction

  function automatic logic [7:0] pick_ws();
    if ($urandom_range(5) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // mostly well-formed strings with random content, the rest random bytes
  task automatic send_random_fmt();
    logic [7:0] text_q[$];
    int         r;
    int         n_digits;
    r = $urandom_range(99);
    if (r < 80) begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 2)) text_q.push_back(pick_ws());
      if ($urandom_range(2) == 0)
        text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      r = $urandom_range(99);
      if (r < 15) n_digits = 0;
      else if (r < 85) n_digits = $urandom_range(1, 3);
      else n_digits = $urandom_range(4, 9);
      repeat (n_digits) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(9) != 0) text_q.push_back(pick_letter());
      else text_q.push_back(8'($urandom_range(1, 255)));
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(1, 255)));
    end
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(CH_NUL);
  endtask

  // hold the sender off until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.parsed_fmts.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct);
    int stop_at;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stop_at        = chars_sent + CHARS_PER_PHASE;
    while (chars_sent < stop_at) send_random_fmt();
    drain_results();
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct   = 21;
    sink_stall_pct = 59;

    // directed: empty string, bare letter, negative bit count,
    // saturating counts of both signs, sign with no digits,
    // digits running into the end, zero count
    send_string("");
    send_string("X");
    send_string("-9X");
    send_string("9999999Q");
    send_string("-9999999C");
    send_string(" +");
    send_string("5");
    send_string("0J");

    // random strings under three idle mixes
    run_phase(21, 59);
    run_phase(59, 21);
    run_phase(0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters in %0d format strings, directed cases and three idle mixes",
             chars_sent, strings_sent);
    $display("checked %0d results, %0d with a recognized letter, %0d mismatches",
             sb.n_checked, sb.n_known, sb.n_errors);
    if (sb.n_errors == 0 && sb.parsed_fmts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
